// ===== hw/rtl/mhsi_pkg.sv =====
// Shared constants, types and register codes of the magnetometer calibration unit.
`default_nettype none

package mhsi_pkg;

  localparam int NUM_AXES = 3;
  localparam int AXIS_W = 2;

  localparam int SAMPLE_W = 16;
  localparam int BIAS_W = 22;
  localparam int SCALE_W = 16;
  localparam int RES_W = 16;
  localparam int ADJ_W = 8;
  localparam int ADJP_W = ADJ_W + 1;

  localparam int SCALE_FRAC_BITS = 12;

  // Half spans fit in 15 bits; three of them in 17 bits.
  localparam int SPAN_W = SAMPLE_W - 1;
  localparam int SUM_W = SPAN_W + 2;
  localparam int DEN_W = SPAN_W + 2;
  localparam int NUM_W = SUM_W + SCALE_FRAC_BITS;
  localparam int DVD_W = NUM_W + 2;
  localparam int DVS_W = DEN_W + 1;
  localparam int CNT_W = $clog2(DVD_W + 1);

  // Bias product: |b| * resolution * (adjust + 128).
  localparam int MAG_W = SAMPLE_W + 1;
  localparam int KPROD_W = RES_W + ADJP_W;
  localparam int PROD_W = KPROD_W + MAG_W;
  localparam int ROUND_SHIFT = 16;
  localparam int RND_W = PROD_W - ROUND_SHIFT;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

  localparam logic [ADJP_W-1:0] ADJ_OFFSET = ADJP_W'(128);
  localparam logic [BIAS_W-1:0] BIAS_POS_MAX = {1'b0, {(BIAS_W - 1){1'b1}}};
  localparam logic [BIAS_W-1:0] BIAS_NEG_MAG = {1'b1, {(BIAS_W - 1){1'b0}}};
  localparam logic [SCALE_W-1:0] SCALE_SAT = {SCALE_W{1'b1}};

  localparam logic signed [SAMPLE_W-1:0] TRACK_HI = 16'sd32760;
  localparam logic signed [SAMPLE_W-1:0] TRACK_LO = -16'sd32760;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ADJUST_X = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ADJUST_Y = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ADJUST_Z = 2'd3;
  localparam logic [RES_W-1:0] RES_RESET = 16'd9830;
  localparam logic [ADJ_W-1:0] ADJ_RESET = 8'd128;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } trk_ctl_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mhsi_track.sv =====
// Per-axis running minimum and maximum tracker.
`default_nettype none

module mhsi_track (
  input  logic                  clk,
  input  logic                  rst,
  input  mhsi_pkg::trk_ctl_t    ctl,
  input  mhsi_pkg::sample_t     samples [mhsi_pkg::NUM_AXES],
  output mhsi_pkg::sample_t     max_next [mhsi_pkg::NUM_AXES],
  output mhsi_pkg::sample_t     min_next [mhsi_pkg::NUM_AXES]
);

  mhsi_pkg::sample_t axis_max [mhsi_pkg::NUM_AXES];
  mhsi_pkg::sample_t axis_min [mhsi_pkg::NUM_AXES];

  always_comb begin
    for (int i = 0; i < mhsi_pkg::NUM_AXES; i++) begin
      max_next[i] = (samples[i] > axis_max[i]) ? samples[i] : axis_max[i];
      min_next[i] = (samples[i] < axis_min[i]) ? samples[i] : axis_min[i];
    end
  end

  // The final item of a run is tracked and handed out, then the bounds start over.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mhsi_pkg::NUM_AXES; i++) begin
        axis_max[i] <= mhsi_pkg::TRACK_LO;
        axis_min[i] <= mhsi_pkg::TRACK_HI;
      end
    end else if (ctl.upd) begin
      for (int i = 0; i < mhsi_pkg::NUM_AXES; i++) begin
        axis_max[i] <= ctl.clr ? mhsi_pkg::TRACK_LO : max_next[i];
        axis_min[i] <= ctl.clr ? mhsi_pkg::TRACK_HI : min_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mhsi_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module mhsi_div (
  input  logic               clk,
  input  logic               rst,
  input  mhsi_pkg::div_req_t req,
  output mhsi_pkg::div_rsp_t rsp
);

  logic                             busy;
  logic                             done;
  logic [mhsi_pkg::CNT_W-1:0]       cnt;
  logic [mhsi_pkg::DVS_W-1:0]       rem;
  logic [mhsi_pkg::DVS_W-1:0]       dvs;
  logic [mhsi_pkg::DVD_W-1:0]       quo;
  logic [mhsi_pkg::DVS_W:0]         trial;
  logic [mhsi_pkg::DVS_W:0]         diff;
  logic                             fits;

  assign trial = {rem, quo[mhsi_pkg::DVD_W-1]};
  assign diff = trial - {1'b0, dvs};
  assign fits = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= mhsi_pkg::CNT_W'(mhsi_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mhsi_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (busy) begin
      rem <= fits ? diff[mhsi_pkg::DVS_W-1:0] : trial[mhsi_pkg::DVS_W-1:0];
      quo <= {quo[mhsi_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== hw/rtl/mag_hard_soft_iron_calibration_unit.sv =====
// Top level: register port, min/max tracking, and the calibration sequencer.
//
//   channel  direction  handshake            content
//   in       to block   in_valid/in_ready    sample_x/y/z, last_sample
//   out      from block out_valid/out_ready  bias_x/y/z, scale_x/y/z, zero_span
//   cfg      to block   APB, pready high     resolution_q16, adjust_x/y/z
//
// An item without last_sample is tracked as it is taken and in_ready stays high.
// An item with last_sample keeps in_ready low while the result is computed; each axis runs
// two passes of the shared multiplier and, for a nonzero span, 31 steps of the shared divider.
// The result waits in an output register, so input items are taken while it stalls;
// a further result is held in ST_OUT, with in_ready low, until that register frees.
// Reset is synchronous and restores the register defaults and the tracker bounds.
`default_nettype none

module mag_hard_soft_iron_calibration_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mhsi_pkg::SAMPLE_W-1:0] sample_x,
  input  logic signed [mhsi_pkg::SAMPLE_W-1:0] sample_y,
  input  logic signed [mhsi_pkg::SAMPLE_W-1:0] sample_z,
  input  logic                                 last_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mhsi_pkg::BIAS_W-1:0]   bias_x,
  output logic signed [mhsi_pkg::BIAS_W-1:0]   bias_y,
  output logic signed [mhsi_pkg::BIAS_W-1:0]   bias_z,
  output logic [mhsi_pkg::SCALE_W-1:0]         scale_x,
  output logic [mhsi_pkg::SCALE_W-1:0]         scale_y,
  output logic [mhsi_pkg::SCALE_W-1:0]         scale_z,
  output logic [mhsi_pkg::NUM_AXES-1:0]        zero_span,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mhsi_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mhsi_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mhsi_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_SUMS = 4'd2;
  localparam logic [3:0] ST_MUL1 = 4'd3;
  localparam logic [3:0] ST_MUL2 = 4'd4;
  localparam logic [3:0] ST_BIAS = 4'd5;
  localparam logic [3:0] ST_DIVW = 4'd6;
  localparam logic [3:0] ST_NEXT = 4'd7;
  localparam logic [3:0] ST_OUT = 4'd8;

  localparam logic [mhsi_pkg::AXIS_W-1:0] LAST_AXIS = mhsi_pkg::AXIS_W'(mhsi_pkg::NUM_AXES - 1);

  // Configuration registers.
  logic [mhsi_pkg::RES_W-1:0]     resolution_q16;
  logic [mhsi_pkg::ADJ_W-1:0]     adjust [mhsi_pkg::NUM_AXES];
  logic                           cfg_wr;
  logic [mhsi_pkg::REG_IDX_W-1:0] reg_idx;

  // Sequencer.
  logic [3:0]                    state;
  logic [3:0]                    state_next;
  logic [mhsi_pkg::AXIS_W-1:0]   axis;
  logic                          in_acc;
  logic                          out_load;

  // Tracker and snapshot of the finished run.
  mhsi_pkg::trk_ctl_t trk_ctl;
  mhsi_pkg::sample_t  samples [mhsi_pkg::NUM_AXES];
  mhsi_pkg::sample_t  max_next [mhsi_pkg::NUM_AXES];
  mhsi_pkg::sample_t  min_next [mhsi_pkg::NUM_AXES];
  mhsi_pkg::sample_t  snap_max [mhsi_pkg::NUM_AXES];
  mhsi_pkg::sample_t  snap_min [mhsi_pkg::NUM_AXES];

  // Working registers.
  logic [mhsi_pkg::SPAN_W-1:0]          span_r [mhsi_pkg::NUM_AXES];
  logic [mhsi_pkg::SUM_W-1:0]           sum_r;
  logic [mhsi_pkg::PROD_W-1:0]          prod;
  logic signed [mhsi_pkg::BIAS_W-1:0]   bias_r [mhsi_pkg::NUM_AXES];
  logic [mhsi_pkg::SCALE_W-1:0]         scale_r [mhsi_pkg::NUM_AXES];
  logic [mhsi_pkg::NUM_AXES-1:0]        zero_r;

  // Per-axis datapath.
  logic signed [mhsi_pkg::SAMPLE_W:0]   pair_sum;
  logic signed [mhsi_pkg::SAMPLE_W:0]   pair_adj;
  logic signed [mhsi_pkg::SAMPLE_W:0]   b_val;
  logic                                 b_neg;
  logic [mhsi_pkg::MAG_W-1:0]           mag;
  logic signed [mhsi_pkg::SAMPLE_W:0]   span_diff [mhsi_pkg::NUM_AXES];
  logic [mhsi_pkg::ADJP_W-1:0]          adjp;
  logic [mhsi_pkg::KPROD_W-1:0]         mul_a;
  logic [mhsi_pkg::MAG_W-1:0]           mul_b;
  logic [mhsi_pkg::PROD_W-1:0]          mul_p;
  logic [mhsi_pkg::PROD_W-1:0]          rnd;
  logic [mhsi_pkg::RND_W-1:0]           qb;
  logic [mhsi_pkg::BIAS_W-1:0]          q_lim;
  logic signed [mhsi_pkg::BIAS_W-1:0]   bias_val;
  logic [mhsi_pkg::SPAN_W-1:0]          span_sel;
  logic [mhsi_pkg::DEN_W-1:0]           den;
  logic [mhsi_pkg::SCALE_W-1:0]         scale_val;
  mhsi_pkg::div_req_t                   div_req;
  mhsi_pkg::div_rsp_t                   div_rsp;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign reg_idx = paddr[mhsi_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution_q16 <= mhsi_pkg::RES_RESET;
      for (int i = 0; i < mhsi_pkg::NUM_AXES; i++) begin
        adjust[i] <= mhsi_pkg::ADJ_RESET;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        mhsi_pkg::REG_RESOLUTION: resolution_q16 <= pwdata[mhsi_pkg::RES_W-1:0];
        mhsi_pkg::REG_ADJUST_X:   adjust[0] <= pwdata[mhsi_pkg::ADJ_W-1:0];
        mhsi_pkg::REG_ADJUST_Y:   adjust[1] <= pwdata[mhsi_pkg::ADJ_W-1:0];
        mhsi_pkg::REG_ADJUST_Z:   adjust[2] <= pwdata[mhsi_pkg::ADJ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mhsi_pkg::REG_RESOLUTION: prdata = mhsi_pkg::APB_DATA_W'(resolution_q16);
      mhsi_pkg::REG_ADJUST_X:   prdata = mhsi_pkg::APB_DATA_W'(adjust[0]);
      mhsi_pkg::REG_ADJUST_Y:   prdata = mhsi_pkg::APB_DATA_W'(adjust[1]);
      mhsi_pkg::REG_ADJUST_Z:   prdata = mhsi_pkg::APB_DATA_W'(adjust[2]);
      default:                  prdata = '0;
    endcase
  end

  // ---------------- tracking ----------------
  assign in_ready = (state == ST_IDLE);
  assign in_acc = in_valid & in_ready;
  assign trk_ctl.upd = in_acc;
  assign trk_ctl.clr = last_sample;
  assign samples[0] = sample_x;
  assign samples[1] = sample_y;
  assign samples[2] = sample_z;

  mhsi_track u_track (
    .clk      (clk),
    .rst      (rst),
    .ctl      (trk_ctl),
    .samples  (samples),
    .max_next (max_next),
    .min_next (min_next)
  );

  // ---------------- per-axis arithmetic ----------------
  always_comb begin
    for (int i = 0; i < mhsi_pkg::NUM_AXES; i++) begin
      span_diff[i] = {snap_max[i][mhsi_pkg::SAMPLE_W-1], snap_max[i]}
                   - {snap_min[i][mhsi_pkg::SAMPLE_W-1], snap_min[i]};
    end
  end

  // Halving the pair sum truncates toward zero: add one before the shift when negative.
  assign pair_sum = {snap_max[axis][mhsi_pkg::SAMPLE_W-1], snap_max[axis]}
                  + {snap_min[axis][mhsi_pkg::SAMPLE_W-1], snap_min[axis]};
  assign b_neg = pair_sum[mhsi_pkg::SAMPLE_W];
  assign pair_adj = pair_sum + {{mhsi_pkg::SAMPLE_W{1'b0}}, b_neg};
  assign b_val = pair_adj >>> 1;
  assign mag = b_neg ? mhsi_pkg::MAG_W'(-b_val) : mhsi_pkg::MAG_W'(b_val);

  assign adjp = {1'b0, adjust[axis]} + mhsi_pkg::ADJ_OFFSET;

  // One multiplier serves both products of an axis.
  always_comb begin
    if (state == ST_MUL1) begin
      mul_a = mhsi_pkg::KPROD_W'(resolution_q16);
      mul_b = mhsi_pkg::MAG_W'(adjp);
    end else begin
      mul_a = prod[mhsi_pkg::KPROD_W-1:0];
      mul_b = mag;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign rnd = prod + mhsi_pkg::ROUND_HALF;
  assign qb = rnd[mhsi_pkg::PROD_W-1:mhsi_pkg::ROUND_SHIFT];

  always_comb begin
    if (b_neg) begin
      q_lim = (qb > mhsi_pkg::RND_W'(mhsi_pkg::BIAS_NEG_MAG)) ? mhsi_pkg::BIAS_NEG_MAG
                                                              : qb[mhsi_pkg::BIAS_W-1:0];
      bias_val = ~q_lim + 1'b1;
    end else begin
      q_lim = (qb > mhsi_pkg::RND_W'(mhsi_pkg::BIAS_POS_MAX)) ? mhsi_pkg::BIAS_POS_MAX
                                                              : qb[mhsi_pkg::BIAS_W-1:0];
      bias_val = q_lim;
    end
  end

  // Scale is round(sum * 2^F / (3 * span)), formed as (2*num + den) / (2*den).
  assign span_sel = span_r[axis];
  assign den = (mhsi_pkg::DEN_W'(span_sel) << 1) + mhsi_pkg::DEN_W'(span_sel);
  assign div_req.start = (state == ST_BIAS) && (span_sel != '0);
  assign div_req.dividend = mhsi_pkg::DVD_W'({sum_r, {mhsi_pkg::SCALE_FRAC_BITS{1'b0}}, 1'b0})
                          + mhsi_pkg::DVD_W'(den);
  assign div_req.divisor = {den, 1'b0};

  mhsi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign scale_val = (|div_rsp.quotient[mhsi_pkg::DVD_W-1:mhsi_pkg::SCALE_W])
                   ? mhsi_pkg::SCALE_SAT : div_rsp.quotient[mhsi_pkg::SCALE_W-1:0];

  // ---------------- sequencer ----------------
  assign out_load = (state == ST_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc && last_sample) state_next = ST_PREP;
      ST_PREP: state_next = ST_SUMS;
      ST_SUMS: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_BIAS;
      ST_BIAS: state_next = (span_sel == '0) ? ST_NEXT : ST_DIVW;
      ST_DIVW: if (div_rsp.done) state_next = ST_NEXT;
      ST_NEXT: state_next = (axis == LAST_AXIS) ? ST_OUT : ST_MUL1;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SUMS) begin
        axis <= '0;
      end else if (state == ST_NEXT && axis != LAST_AXIS) begin
        axis <= axis + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_sample) begin
      for (int i = 0; i < mhsi_pkg::NUM_AXES; i++) begin
        snap_max[i] <= max_next[i];
        snap_min[i] <= min_next[i];
      end
    end
    if (state == ST_PREP) begin
      for (int i = 0; i < mhsi_pkg::NUM_AXES; i++) begin
        span_r[i] <= span_diff[i][mhsi_pkg::SAMPLE_W] ? '0
                   : span_diff[i][mhsi_pkg::SAMPLE_W-1:1];
      end
    end
    if (state == ST_SUMS) begin
      sum_r <= mhsi_pkg::SUM_W'(span_r[0]) + mhsi_pkg::SUM_W'(span_r[1])
             + mhsi_pkg::SUM_W'(span_r[2]);
    end
    if (state == ST_MUL1 || state == ST_MUL2) begin
      prod <= mul_p;
    end
    if (state == ST_BIAS) begin
      bias_r[axis] <= bias_val;
      zero_r[axis] <= (span_sel == '0);
      if (span_sel == '0) begin
        scale_r[axis] <= mhsi_pkg::SCALE_SAT;
      end
    end
    if (state == ST_DIVW && div_rsp.done) begin
      scale_r[axis] <= scale_val;
    end
    if (out_load) begin
      bias_x <= bias_r[0];
      bias_y <= bias_r[1];
      bias_z <= bias_r[2];
      scale_x <= scale_r[0];
      scale_y <= scale_r[1];
      scale_z <= scale_r[2];
      zero_span <= zero_r;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mhsi_chk.sv =====
// Port-level checks of the calibration unit, bound to its top level.
`default_nettype none

module mhsi_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 last_sample,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [mhsi_pkg::BIAS_W-1:0]   bias_x,
  input logic signed [mhsi_pkg::BIAS_W-1:0]   bias_y,
  input logic signed [mhsi_pkg::BIAS_W-1:0]   bias_z,
  input logic [mhsi_pkg::SCALE_W-1:0]         scale_x,
  input logic [mhsi_pkg::SCALE_W-1:0]         scale_y,
  input logic [mhsi_pkg::SCALE_W-1:0]         scale_z,
  input logic [mhsi_pkg::NUM_AXES-1:0]        zero_span
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bias_x) && $stable(bias_y)
      && $stable(bias_z) && $stable(scale_x) && $stable(scale_y) && $stable(scale_z)
      && $stable(zero_span))
    else $error("result item changed while stalled");

  // An axis flagged with a zero span reports the largest scale.
  a_zero_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!zero_span[0] || scale_x == mhsi_pkg::SCALE_SAT)
      && (!zero_span[1] || scale_y == mhsi_pkg::SCALE_SAT)
      && (!zero_span[2] || scale_z == mhsi_pkg::SCALE_SAT))
    else $error("zero span flag without saturated scale");

  // The final item of a run starts the computation, which holds off input.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_sample |=> !in_ready)
    else $error("input taken right after the final item of a run");

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind mag_hard_soft_iron_calibration_unit mhsi_chk u_mhsi_chk (.*);

`default_nettype wire

// ===== tb/mhsi_calibration_checker.sv =====
`timescale 1ns / 1ps
// Checker for the calibration unit: tracks the samples, predicts each result and compares it.
module mhsi_calibration_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [mhsi_pkg::SAMPLE_W-1:0] sample_x,
  input  logic signed [mhsi_pkg::SAMPLE_W-1:0] sample_y,
  input  logic signed [mhsi_pkg::SAMPLE_W-1:0] sample_z,
  input  logic                                 last_sample,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [mhsi_pkg::BIAS_W-1:0]   bias_x,
  input  logic signed [mhsi_pkg::BIAS_W-1:0]   bias_y,
  input  logic signed [mhsi_pkg::BIAS_W-1:0]   bias_z,
  input  logic [mhsi_pkg::SCALE_W-1:0]         scale_x,
  input  logic [mhsi_pkg::SCALE_W-1:0]         scale_y,
  input  logic [mhsi_pkg::SCALE_W-1:0]         scale_z,
  input  logic [mhsi_pkg::NUM_AXES-1:0]        zero_span,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mhsi_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mhsi_pkg::APB_DATA_W-1:0]      pwdata,
  input  logic [mhsi_pkg::APB_DATA_W-1:0]      prdata,
  input  logic                                 pready,
  output int                                   cal_errors,
  output int                                   cals_outstanding
);
  import mhsi_pkg::*;

  typedef struct packed {
    logic [NUM_AXES-1:0][BIAS_W-1:0]  bias;
    logic [NUM_AXES-1:0][SCALE_W-1:0] scale;
    logic [NUM_AXES-1:0]              zspan;
  } cal_result_t;

  cal_result_t      awaited_cals[$];
  logic [RES_W-1:0] res_q16;
  logic [ADJ_W-1:0] adj[NUM_AXES];
  int               axis_hi[NUM_AXES];
  int               axis_lo[NUM_AXES];

  function automatic void clear_trackers();
    for (int k = 0; k < NUM_AXES; k++) begin
      axis_hi[k] = int'(TRACK_LO);
      axis_lo[k] = int'(TRACK_HI);
    end
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_readback(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_RESOLUTION: return APB_DATA_W'(res_q16);
      REG_ADJUST_X:   return APB_DATA_W'(adj[0]);
      REG_ADJUST_Y:   return APB_DATA_W'(adj[1]);
      REG_ADJUST_Z:   return APB_DATA_W'(adj[2]);
      default:        return '0;
    endcase
  endfunction

  // Bias and scale from the current trackers, with the registers as they stand now.
  function automatic cal_result_t predict_calibration();
    cal_result_t r;
    int          mid;
    int          half[NUM_AXES];
    longint      span_sum;
    longint      mag;
    longint      q;
    longint      num;
    longint      den;
    r = '0;
    span_sum = 0;
    for (int k = 0; k < NUM_AXES; k++) begin
      mid = (axis_hi[k] + axis_lo[k]) / 2;
      mag = (mid < 0) ? -longint'(mid) : longint'(mid);
      q = (mag * longint'(res_q16) * (longint'(adj[k]) + 128) + 32768) >>> 16;
      if (mid < 0) begin
        if (q > longint'(BIAS_NEG_MAG)) q = longint'(BIAS_NEG_MAG);
        r.bias[k] = BIAS_W'(-q);
      end else begin
        if (q > longint'(BIAS_POS_MAX)) q = longint'(BIAS_POS_MAX);
        r.bias[k] = BIAS_W'(q);
      end
      half[k] = (axis_hi[k] - axis_lo[k]) / 2;
      if (half[k] < 0) half[k] = 0;
      span_sum += half[k];
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      if (half[k] == 0) begin
        r.scale[k] = SCALE_SAT;
        r.zspan[k] = 1'b1;
      end else begin
        num = span_sum << SCALE_FRAC_BITS;
        den = 3 * longint'(half[k]);
        q = (2 * num + den) / (2 * den);
        if (q > longint'(SCALE_SAT)) q = longint'(SCALE_SAT);
        r.scale[k] = SCALE_W'(q);
      end
    end
    return r;
  endfunction

  task automatic log_mismatch(string what, longint want, longint got);
    cal_errors++;
    if (cal_errors <= 10) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    cal_result_t got;
    cal_result_t want;
    int          smp[NUM_AXES];
    if (rst) begin
      res_q16 = RES_RESET;
      for (int k = 0; k < NUM_AXES; k++) adj[k] = ADJ_RESET;
      clear_trackers();
      awaited_cals.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[APB_ADDR_W-1:2])
            REG_RESOLUTION: res_q16 = pwdata[RES_W-1:0];
            REG_ADJUST_X:   adj[0] = pwdata[ADJ_W-1:0];
            REG_ADJUST_Y:   adj[1] = pwdata[ADJ_W-1:0];
            REG_ADJUST_Z:   adj[2] = pwdata[ADJ_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_readback(paddr[APB_ADDR_W-1:2])) begin
          log_mismatch($sformatf("readback of register at 0x%0h", paddr),
                       reg_readback(paddr[APB_ADDR_W-1:2]), prdata);
        end
      end

      if (out_valid && out_ready) begin
        got.bias  = {bias_z, bias_y, bias_x};
        got.scale = {scale_z, scale_y, scale_x};
        got.zspan = zero_span;
        if (awaited_cals.size() == 0) begin
          log_mismatch("result count (item with none outstanding)", 0, 1);
        end else begin
          want = awaited_cals.pop_front();
          for (int k = 0; k < NUM_AXES; k++) begin
            if (got.bias[k] !== want.bias[k]) begin
              log_mismatch($sformatf("bias of axis %0d", k),
                           longint'($signed(want.bias[k])), longint'($signed(got.bias[k])));
            end
            if (got.scale[k] !== want.scale[k]) begin
              log_mismatch($sformatf("scale of axis %0d", k), want.scale[k], got.scale[k]);
            end
          end
          if (got.zspan !== want.zspan) log_mismatch("zero_span", want.zspan, got.zspan);
        end
      end

      if (in_valid && in_ready) begin
        smp[0] = sample_x;
        smp[1] = sample_y;
        smp[2] = sample_z;
        for (int k = 0; k < NUM_AXES; k++) begin
          if (smp[k] > axis_hi[k]) axis_hi[k] = smp[k];
          if (smp[k] < axis_lo[k]) axis_lo[k] = smp[k];
        end
        // The marked item is tracked first, then closes the run.
        if (last_sample) begin
          awaited_cals.push_back(predict_calibration());
          clear_trackers();
        end
      end
    end
    cals_outstanding = awaited_cals.size();
  end

endmodule

// ===== tb/mag_hard_soft_iron_calibration_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the calibration unit: clock, reset, stimulus, back-pressure and verdict.
module mag_hard_soft_iron_calibration_unit_test;
  import mhsi_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD = 500;
  localparam int PHASE_ITEMS = 220;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  sample_t                      sample_x;
  sample_t                      sample_y;
  sample_t                      sample_z;
  logic                         last_sample;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [BIAS_W-1:0]     bias_x;
  logic signed [BIAS_W-1:0]     bias_y;
  logic signed [BIAS_W-1:0]     bias_z;
  logic [SCALE_W-1:0]           scale_x;
  logic [SCALE_W-1:0]           scale_y;
  logic [SCALE_W-1:0]           scale_z;
  logic [NUM_AXES-1:0]          zero_span;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [APB_ADDR_W-1:0]        paddr;
  logic [APB_DATA_W-1:0]        pwdata;
  logic [APB_DATA_W-1:0]        prdata;
  logic                         pready;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int cycle_count;
  int cal_errors;
  int cals_outstanding;

  mag_hard_soft_iron_calibration_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
    .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .bias_x(bias_x), .bias_y(bias_y), .bias_z(bias_z),
    .scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
    .zero_span(zero_span),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mhsi_calibration_checker u_cal_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .sample_x(sample_x), .sample_y(sample_y), .sample_z(sample_z),
    .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .bias_x(bias_x), .bias_y(bias_y), .bias_z(bias_z),
    .scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
    .zero_span(zero_span),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cal_errors(cal_errors), .cals_outstanding(cals_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mag_hard_soft_iron_calibration_unit_test: errors");
    $finish;
  end

  // Result side: random stalls, or a long hold-off once the stimulus asks for one.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so a following item can go out without a gap.
  task automatic send_item(sample_t x, sample_t y, sample_t z, logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample_x <= x;
    sample_y <= y;
    sample_z <= z;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pause_until_drained(int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (cals_outstanding != 0);
    repeat (extra) @(negedge clk);
  endtask

  task automatic apb_access(logic write, logic [REG_IDX_W-1:0] idx,
                            logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_registers();
    apb_access(1'b0, REG_RESOLUTION, '0);
    apb_access(1'b0, REG_ADJUST_X, '0);
    apb_access(1'b0, REG_ADJUST_Y, '0);
    apb_access(1'b0, REG_ADJUST_Z, '0);
  endtask

  // Upper data bits carry junk; the block must drop them.
  task automatic configure(logic [RES_W-1:0] res, logic [ADJ_W-1:0] ax,
                           logic [ADJ_W-1:0] ay, logic [ADJ_W-1:0] az);
    apb_access(1'b1, REG_RESOLUTION, ($urandom & 32'hFFFF_0000) | APB_DATA_W'(res));
    apb_access(1'b1, REG_ADJUST_X, ($urandom & 32'hFFFF_FF00) | APB_DATA_W'(ax));
    apb_access(1'b1, REG_ADJUST_Y, ($urandom & 32'hFFFF_FF00) | APB_DATA_W'(ay));
    apb_access(1'b1, REG_ADJUST_Z, ($urandom & 32'hFFFF_FF00) | APB_DATA_W'(az));
    read_registers();
  endtask

  function automatic logic [ADJ_W-1:0] draw_adjust();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ADJ_W'($urandom);
    endcase
  endfunction

  task automatic random_config();
    logic [RES_W-1:0] res;
    case ($urandom_range(7))
      0:       res = '0;
      1:       res = '1;
      2:       res = RES_W'(1);
      default: res = RES_W'($urandom);
    endcase
    configure(res, draw_adjust(), draw_adjust(), draw_adjust());
  endtask

  // Mostly a cloud around a per-run center; some full-range and boundary values.
  function automatic sample_t draw_sample(int centre, int amp);
    int v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) return sample_t'($urandom);
    if (pick < 30) begin
      case ($urandom_range(5))
        0:       return -32768;
        1:       return 32767;
        2:       return -32760;
        3:       return 32760;
        4:       return -1;
        default: return 0;
      endcase
    end
    v = centre + int'($urandom_range(2 * amp)) - amp;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  function automatic int draw_run_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 1;
    if (pick < 85) return $urandom_range(2, 40);
    return $urandom_range(41, 120);
  endfunction

  task automatic send_run(int len);
    int centre[NUM_AXES];
    int amp[NUM_AXES];
    for (int k = 0; k < NUM_AXES; k++) begin
      centre[k] = int'($urandom_range(48000)) - 24000;
      amp[k] = ($urandom_range(6) == 0) ? $urandom_range(2) : $urandom_range(1, 20000);
    end
    for (int i = 0; i < len; i++) begin
      send_item(draw_sample(centre[0], amp[0]), draw_sample(centre[1], amp[1]),
                draw_sample(centre[2], amp[2]), i == len - 1);
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int budget);
    int sent;
    int len;
    sent = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < budget) begin
      len = draw_run_len();
      send_run(len);
      sent += len;
      if (sent < budget && $urandom_range(15) == 0) pause_until_drained(0);
    end
    pause_until_drained(SETTLE_CYCLES);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sample_x = '0;
    sample_y = '0;
    sample_z = '0;
    last_sample = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults, then runs under the reset configuration.
    read_registers();
    send_item(0, 0, 0, 1'b1);
    send_item(32767, -32768, 100, 1'b0);
    send_item(-32768, 32767, -100, 1'b1);
    send_item(-32768, -32768, -32768, 1'b1);
    send_item(32767, 32767, 32767, 1'b1);
    // One flat axis beside two live ones.
    send_item(5, 1000, -1000, 1'b0);
    send_item(5, -1000, 2000, 1'b1);
    // A tiny span against two full ones drives the scale into saturation.
    send_item(0, -32768, -32768, 1'b0);
    send_item(2, 32767, 32767, 1'b1);
    // A span of one count halves to zero.
    send_item(0, 0, 0, 1'b0);
    send_item(1, 1, 1, 1'b1);
    send_item(-3, -5, 7, 1'b0);
    send_item(-3, -6, 8, 1'b1);
    pause_until_drained(SETTLE_CYCLES);

    // Largest gain: biases saturate at both ends.
    configure('1, '1, '1, '1);
    send_item(32767, 32767, 32767, 1'b1);
    send_item(-32768, -32768, -32768, 1'b1);
    send_item(-32761, 32761, -32760, 1'b1);
    pause_until_drained(SETTLE_CYCLES);

    configure('0, '0, '0, '0);
    send_item(12345, -23456, 32767, 1'b0);
    send_item(-1, 1, -32768, 1'b1);
    pause_until_drained(SETTLE_CYCLES);

    // Smallest nonzero gain puts the bias right on a rounding boundary.
    configure(RES_W'(1), '0, '0, '0);
    send_item(256, -256, 512, 1'b1);
    pause_until_drained(SETTLE_CYCLES);

    // Result side held off while short runs keep coming, so the input stalls.
    configure(RES_RESET, ADJ_RESET, ADJ_RESET, ADJ_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = LONG_HOLD;
    for (int i = 0; i < 40; i++) send_run($urandom_range(1, 3));
    pause_until_drained(SETTLE_CYCLES);

    for (int p = 0; p < 8; p++) begin
      random_config();
      case (p % 4)
        0:       run_phase(0, 0, PHASE_ITEMS);
        1:       run_phase(68, 0, PHASE_ITEMS);
        2:       run_phase(0, 68, PHASE_ITEMS);
        default: run_phase(24, 24, PHASE_ITEMS);
      endcase
    end

    if (cal_errors == 0 && cals_outstanding == 0) begin
      $display("mag_hard_soft_iron_calibration_unit_test: clean");
    end else begin
      $display("mag_hard_soft_iron_calibration_unit_test: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mhsi_pkg.sv
hw/rtl/mhsi_track.sv
hw/rtl/mhsi_div.sv
hw/rtl/mag_hard_soft_iron_calibration_unit.sv
hw/rtl/mhsi_chk.sv
tb/mhsi_calibration_checker.sv
tb/mag_hard_soft_iron_calibration_unit_test.sv
